@@ rtl/rv32_load_store_unit_macros.svh @@
// Assertion macros shared by the load/store unit checker.
`ifndef RV32_LOAD_STORE_UNIT_MACROS_SVH
`define RV32_LOAD_STORE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LSU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("load/store unit assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LSU_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("load/store unit assertion failed");

`endif

@@ rtl/lsu_pkg.sv @@
// ----------------------------------------------------------------------------
// lsu_pkg
// Types and codes shared by the RV32I load/store unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lsu_pkg;

    // Instruction modes
    localparam logic [2:0] MODE_LB  = 3'd0;
    localparam logic [2:0] MODE_LBU = 3'd1;
    localparam logic [2:0] MODE_LH  = 3'd2;
    localparam logic [2:0] MODE_LHU = 3'd3;
    localparam logic [2:0] MODE_LW  = 3'd4;
    localparam logic [2:0] MODE_SB  = 3'd5;
    localparam logic [2:0] MODE_SH  = 3'd6;
    localparam logic [2:0] MODE_SW  = 3'd7;

    // Fault codes
    localparam logic [1:0] FC_LOAD_MISALIGN  = 2'd0;
    localparam logic [1:0] FC_LOAD_ACCESS    = 2'd1;
    localparam logic [1:0] FC_STORE_MISALIGN = 2'd2;
    localparam logic [1:0] FC_STORE_ACCESS   = 2'd3;

    localparam logic [31:0] BYTE_MASK = 32'h0000_00ff;
    localparam logic [31:0] HALF_MASK = 32'h0000_ffff;

    typedef struct packed {
        logic               flush;
        logic               op_valid;
        logic [2:0]         mode;
        logic [31:0]        base_value;
        logic signed [31:0] offset;
        logic [31:0]        store_data;
        logic [5:0]         rob_tag;
    } lsu_in_t;

    typedef struct packed {
        logic        result_valid;
        logic [5:0]  rob_tag_out;
        logic [31:0] load_value;
        logic        fault;
        logic [1:0]  fault_code;
        logic [31:0] fault_address;
    } lsu_out_t;

    // Controller to datapath
    typedef struct packed {
        logic clear;     // write zero at the clear counter, advance it
        logic load_req;  // capture the incoming item
        logic calc;      // form the effective address
        logic access;    // check the address, drive the memory
        logic finish;    // format the result into the output register
    } lsu_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;  // clear counter is on the last word
        logic out_free;  // output register can take a result this cycle
    } lsu_sts_t;

endpackage

`default_nettype wire

@@ rtl/rv32_load_store_unit.sv @@
// ----------------------------------------------------------------------------
// rv32_load_store_unit
// RV32I load/store execution unit with a local byte-addressed data memory.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) takes one memory instruction item:
//   flush, op_valid, mode, base, offset, store data and reorder tag.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one result item
//   for every request item, in order.
//   Steps: the item is captured at the request edge, then the address add,
//   the memory access and the format step follow in turn, and the result
//   shows on rsp after the format step. One item is in flight at a time
//   and the next is taken in the cycle after the format step; the
//   registered read data of the memory give the access a step of its own.
//   The output register parts the two sides: the next item is accepted
//   while a result waits. If rsp_ready stays low, the following item waits
//   in its format step until the output register frees.
//   Reset: the memory is cleared, one 32-bit word per cycle, and req_ready
//   stays low until the pass ends.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32_load_store_unit #(
    parameter int MEM_BYTES = 65536
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire lsu_pkg::lsu_in_t req,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    output lsu_pkg::lsu_out_t     rsp
);

    import lsu_pkg::*;

    lsu_cmd_t cmd;
    lsu_sts_t sts;

    lsu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    lsu_dp #(
        .MEM_BYTES (MEM_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

@@ rtl/lsu_ram.sv @@
// ----------------------------------------------------------------------------
// lsu_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  wire logic                                         clk,
    input  wire logic                                         en,
    input  wire logic                                         we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                             wdata,
    output logic      [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/lsu_ctrl.sv @@
// ----------------------------------------------------------------------------
// lsu_ctrl
// Sequencer for the load/store unit: clear pass, then one item at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module lsu_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire lsu_pkg::lsu_sts_t sts,
    output lsu_pkg::lsu_cmd_t      cmd
);

    import lsu_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_CALC   = 3'd2;
    localparam logic [2:0] ST_ACCESS = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        req_ready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_ACCESS;
            end
            ST_ACCESS:
            begin
                cmd.access = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold here while the previous result is still unclaimed
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/lsu_dp.sv @@
// ----------------------------------------------------------------------------
// lsu_dp
// Datapath: address adder, fault checks, four byte-lane RAMs, load
// extraction and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lsu_dp #(
    parameter int MEM_BYTES = 65536
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lsu_pkg::lsu_cmd_t cmd,
    output lsu_pkg::lsu_sts_t      sts,
    input  wire lsu_pkg::lsu_in_t  req,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output lsu_pkg::lsu_out_t      rsp
);

    import lsu_pkg::*;

    localparam int WORDS = (MEM_BYTES + 3) / 4;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [32:0]   MEM_LIMIT = 33'(MEM_BYTES);
    localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

    lsu_in_t       req_reg;
    logic [31:0]   addr_reg;
    logic          fault_reg;
    logic          misal_reg;
    logic          store_reg;
    logic [AW-1:0] clr_cnt_reg;
    lsu_out_t      rsp_reg;
    logic          rsp_valid_reg;

    logic          is_store;
    logic          size_byte;
    logic          size_half;
    logic [2:0]    size_val;
    logic          misal;
    logic          beyond;
    logic          fault;
    logic          perform;
    logic [AW-1:0] ram_addr;
    logic [3:0]    ram_en;
    logic          ram_we;
    logic [7:0]    ram_wdata [4];
    logic [7:0]    ram_q [4];
    logic [31:0]   raw_val;
    logic [31:0]   load_val;
    lsu_out_t      rsp_next;

    // ---- decode and checks (from captured item and address)
    always_comb
    begin
        is_store  = (req_reg.mode >= MODE_SB);
        size_byte = (req_reg.mode == MODE_LB) || (req_reg.mode == MODE_LBU) ||
                    (req_reg.mode == MODE_SB);
        size_half = (req_reg.mode == MODE_LH) || (req_reg.mode == MODE_LHU) ||
                    (req_reg.mode == MODE_SH);
        size_val  = size_byte ? 3'd1 : (size_half ? 3'd2 : 3'd4);
        misal     = size_half ? addr_reg[0] : (!size_byte && (addr_reg[1:0] != 2'b00));
        beyond    = ({1'b0, addr_reg} + {30'b0, size_val}) > MEM_LIMIT;
        fault     = misal || beyond;
        perform   = !req_reg.flush && req_reg.op_valid;
    end

    // ---- memory lanes
    always_comb
    begin
        ram_addr = cmd.clear ? clr_cnt_reg : addr_reg[AW+1:2];
        ram_we   = cmd.clear || is_store;
        for (int k = 0; k < 4; k++)
        begin
            logic sel;
            sel = size_byte ? (addr_reg[1:0] == 2'(k)) :
                  (size_half ? (addr_reg[1] == 1'(k >> 1)) : 1'b1);
            ram_en[k] = cmd.clear ||
                        (cmd.access && perform && !fault && (!is_store || sel));
            if (cmd.clear)
            begin
                ram_wdata[k] = 8'h00;
            end
            else if (size_byte)
            begin
                ram_wdata[k] = req_reg.store_data[7:0];
            end
            else if (size_half)
            begin
                ram_wdata[k] = req_reg.store_data[8*(k & 1) +: 8];
            end
            else
            begin
                ram_wdata[k] = req_reg.store_data[8*k +: 8];
            end
        end
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        lsu_ram #(
            .WIDTH (8),
            .DEPTH (WORDS)
        ) u_ram (
            .clk   (clk),
            .en    (ram_en[g]),
            .we    (ram_we),
            .addr  (ram_addr),
            .wdata (ram_wdata[g]),
            .rdata (ram_q[g])
        );
    end

    // ---- load extraction and result
    always_comb
    begin
        if (size_byte)
        begin
            raw_val = {24'b0, ram_q[addr_reg[1:0]]};
        end
        else if (size_half)
        begin
            raw_val = addr_reg[1] ? {16'b0, ram_q[3], ram_q[2]} : {16'b0, ram_q[1], ram_q[0]};
        end
        else
        begin
            raw_val = {ram_q[3], ram_q[2], ram_q[1], ram_q[0]};
        end

        load_val = raw_val;
        if ((req_reg.mode == MODE_LB) && raw_val[7])
        begin
            load_val = raw_val | ~BYTE_MASK;
        end
        else if ((req_reg.mode == MODE_LH) && raw_val[15])
        begin
            load_val = raw_val | ~HALF_MASK;
        end

        rsp_next = '0;
        if (!req_reg.flush)
        begin
            rsp_next.rob_tag_out = req_reg.rob_tag;
            if (req_reg.op_valid)
            begin
                rsp_next.result_valid  = 1'b1;
                rsp_next.fault_address = addr_reg;
                rsp_next.fault         = fault_reg;
                if (fault_reg)
                begin
                    priority if (store_reg && misal_reg)
                        rsp_next.fault_code = FC_STORE_MISALIGN;
                    else if (store_reg)
                        rsp_next.fault_code = FC_STORE_ACCESS;
                    else if (misal_reg)
                        rsp_next.fault_code = FC_LOAD_MISALIGN;
                    else
                        rsp_next.fault_code = FC_LOAD_ACCESS;
                end
                else if (!store_reg)
                begin
                    rsp_next.load_value = load_val;
                end
            end
        end
    end

    // ---- payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req;
        end
        if (cmd.calc)
        begin
            addr_reg <= req_reg.base_value + $unsigned(req_reg.offset);
        end
        if (cmd.access)
        begin
            fault_reg   <= perform && fault;
            misal_reg   <= misal;
            store_reg   <= is_store;
        end
        if (cmd.finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // ---- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear && (clr_cnt_reg != LAST_WORD))
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign sts = '{clr_last: (clr_cnt_reg == LAST_WORD),
                   out_free: (!rsp_valid_reg || rsp_ready)};

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

@@ rtl/lsu_checker.sv @@
// ----------------------------------------------------------------------------
// lsu_checker
// Port-level assertions for the load/store unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rv32_load_store_unit_macros.svh"

module lsu_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              req_valid,
    input wire logic              req_ready,
    input wire logic              rsp_valid,
    input wire logic              rsp_ready,
    input wire lsu_pkg::lsu_out_t rsp
);

    import lsu_pkg::*;

    // a stalled result item holds
    `LSU_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

    // one item in flight: no accept on the cycle after an accept
    `LSU_ASSERT_NXT(a_one_in_flight, req_valid && req_ready, !req_ready)

    // a faulting access never returns load data
    `LSU_ASSERT_IMP(a_fault_no_data, rsp_valid && rsp.fault, rsp.load_value == 32'b0)

    // no fault code without a fault, and no load data without a performed item
    `LSU_ASSERT_IMP(a_code_needs_fault, rsp_valid && !rsp.fault,
        (rsp.fault_code == FC_LOAD_MISALIGN) && (rsp.result_valid || (rsp.load_value == 32'b0)))

endmodule

bind rv32_load_store_unit lsu_checker u_lsu_checker (.*);

`default_nettype wire
